@@ sv/frc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frc_pkg: shared constants for the frame receiver with checksum
// Register indexes, result status codes and port widths used by the
// deframer and its port checker.
// ----------------------------------------------------------------------------
package frc_pkg;

	// default payload store depth in bytes
	localparam int MAX_PAYLOAD_DEF = 16;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int LIMIT_W     = 5;

	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_LIMIT  = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// result status codes
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_BYTE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SUM_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd2;

	// stream widths
	localparam int BYTE_W     = 8;
	localparam int INDEX_W    = 4;
	localparam int OUT_DATA_W = 16;

endpackage : frc_pkg
`default_nettype wire

@@ sv/frame_receiver_checksum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frame_receiver_checksum: sync-header, length and checksum deframer
// Hunts for a two-byte header, reads a length byte, buffers the payload in
// a synchronous RAM while summing it, then checks the checksum byte.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one received serial byte per word (tdata) with an
//   abort flag (tuser[0]) that drops the parser back to the header hunt.
//   Master stream returns result words: packet bytes in order (first is the
//   command code, tlast on the final byte), or a single error word with
//   tlast set (tuser gives the status, tdata is zero).
//   Header and payload bytes are accepted whenever offered. A good checksum
//   starts a readout of the payload RAM in which each byte passes a RAM read
//   state and then an output load state; no input is taken during the
//   readout. Length and checksum bytes are only taken when the output
//   register is free or draining, since they may produce a word.
//   Reset clears the parser to the header hunt, empties the output register
//   and loads the register defaults; the payload RAM is not cleared.
//   A master-side stall holds the output word and freezes the readout.
// ----------------------------------------------------------------------------
module frame_receiver_checksum #(
	parameter int MAX_PAYLOAD = frc_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [frc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [frc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// received bytes
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [frc_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] rx_byte
	input  wire logic                                s_tuser,   // [0] abort
	// result words
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [frc_pkg::OUT_DATA_W-1:0]           m_tdata,   // [7:0] data_byte, [11:8] byte_index
	output logic [frc_pkg::STATUS_W-1:0]             m_tuser,   // [1:0] status
	output logic                                     m_tlast    // last
);

	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LW    = frc_pkg::LIMIT_W;
	localparam int BW    = frc_pkg::BYTE_W;

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		GET_LENGTH,
		GET_PAYLOAD,
		GET_CHECK,
		EMIT_READ,
		EMIT_LOAD
	} state_t;

	state_t          state_q;
	logic [BW-1:0]   header_first_q;
	logic [BW-1:0]   header_second_q;
	logic [LW-1:0]   length_limit_q;
	logic [LW-1:0]   expected_q;
	logic [LW-1:0]   count_q;
	logic [BW-1:0]   sum_q;
	logic [LW-1:0]   emit_idx_q;

	logic            out_valid_q;
	logic [BW-1:0]   out_byte_q;
	logic [frc_pkg::INDEX_W-1:0]  out_index_q;
	logic [frc_pkg::STATUS_W-1:0] out_status_q;
	logic            out_last_q;

	logic [BW-1:0]   payload_mem [MAX_PAYLOAD];
	logic [BW-1:0]   rd_data_s1;

	logic            out_free;
	logic            out_load;
	logic            in_fire;
	logic            byte_fire;
	logic [BW-1:0]   lim_eff;
	logic            len_bad;
	logic [LW-1:0]   count_inc;
	logic [BW-1:0]   sum_inc;
	logic            emit_last;

	// output register frees up when empty or being taken this cycle
	assign out_free = !out_valid_q || m_tready;

	// hold input while reading out, and while a word-producing byte cannot land
	always_comb begin
		case (state_q)
			GET_LENGTH, GET_CHECK: s_tready = out_free;
			EMIT_READ, EMIT_LOAD:  s_tready = 1'b0;
			default:               s_tready = 1'b1;
		endcase
	end

	assign in_fire   = s_tvalid && s_tready;
	assign byte_fire = in_fire && !s_tuser;

	// effective length limit is the smaller of the register and the store depth
	always_comb begin
		if ({{(BW-LW){1'b0}}, length_limit_q} > BW'(MAX_PAYLOAD)) begin
			lim_eff = BW'(MAX_PAYLOAD);
		end else begin
			lim_eff = {{(BW-LW){1'b0}}, length_limit_q};
		end
	end

	assign len_bad   = (s_tdata == '0) || (s_tdata > lim_eff);
	assign count_inc = count_q + 1'b1;
	assign sum_inc   = sum_q + s_tdata;
	assign emit_last = ((emit_idx_q + 1'b1) == expected_q);

	// a new result word enters the output register this cycle
	assign out_load = (byte_fire && state_q == GET_LENGTH && len_bad)
		|| (byte_fire && state_q == GET_CHECK && s_tdata != sum_q)
		|| (state_q == EMIT_LOAD && out_free);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= '0;
			header_second_q <= '0;
			length_limit_q  <= frc_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				frc_pkg::REG_HEADER_FIRST:  header_first_q  <= cfg_data;
				frc_pkg::REG_HEADER_SECOND: header_second_q <= cfg_data;
				frc_pkg::REG_LENGTH_LIMIT:  length_limit_q  <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// payload RAM: write while receiving, registered read during readout.
	// Writes and readout never overlap, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (byte_fire && state_q == GET_PAYLOAD) begin
			payload_mem[AW'(count_q)] <= s_tdata;
		end
		rd_data_s1 <= payload_mem[AW'(emit_idx_q)];
	end

	// parser, readout sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= HUNT_FIRST;
			expected_q   <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			emit_idx_q   <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_index_q  <= '0;
			out_status_q <= frc_pkg::ST_BYTE;
			out_last_q   <= 1'b0;
		end else begin
			// drop the word once taken, unless a new one loads
			if (m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			if (in_fire && s_tuser) begin
				// abort: back to the hunt, byte ignored
				state_q <= HUNT_FIRST;
			end else begin
				case (state_q)
					HUNT_SECOND: begin
						if (byte_fire) begin
							state_q <= (s_tdata == header_second_q) ? GET_LENGTH : HUNT_FIRST;
						end
					end
					GET_LENGTH: begin
						if (byte_fire) begin
							if (len_bad) begin
								out_valid_q  <= 1'b1;
								out_byte_q   <= '0;
								out_index_q  <= '0;
								out_status_q <= frc_pkg::ST_LEN_ERR;
								out_last_q   <= 1'b1;
								state_q      <= HUNT_FIRST;
							end else begin
								expected_q <= s_tdata[LW-1:0];
								count_q    <= '0;
								sum_q      <= '0;
								state_q    <= GET_PAYLOAD;
							end
						end
					end
					GET_PAYLOAD: begin
						if (byte_fire) begin
							sum_q   <= sum_inc;
							count_q <= count_inc;
							if (count_inc >= expected_q) begin
								state_q <= GET_CHECK;
							end
						end
					end
					GET_CHECK: begin
						if (byte_fire) begin
							if (s_tdata == sum_q) begin
								emit_idx_q <= '0;
								state_q    <= EMIT_READ;
							end else begin
								out_valid_q  <= 1'b1;
								out_byte_q   <= '0;
								out_index_q  <= '0;
								out_status_q <= frc_pkg::ST_SUM_ERR;
								out_last_q   <= 1'b1;
								state_q      <= HUNT_FIRST;
							end
						end
					end
					EMIT_READ: begin
						// RAM address is emit_idx_q; data arrives next cycle
						state_q <= EMIT_LOAD;
					end
					EMIT_LOAD: begin
						if (out_free) begin
							out_valid_q  <= 1'b1;
							out_byte_q   <= rd_data_s1;
							out_index_q  <= emit_idx_q[frc_pkg::INDEX_W-1:0];
							out_status_q <= frc_pkg::ST_BYTE;
							out_last_q   <= emit_last;
							if (emit_last) begin
								state_q <= HUNT_FIRST;
							end else begin
								emit_idx_q <= emit_idx_q + 1'b1;
								state_q    <= EMIT_READ;
							end
						end
					end
					default: begin
						if (byte_fire) begin
							state_q <= (s_tdata == header_first_q) ? HUNT_SECOND : HUNT_FIRST;
						end
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(frc_pkg::OUT_DATA_W - BW - frc_pkg::INDEX_W){1'b0}},
		out_index_q, out_byte_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule : frame_receiver_checksum
`default_nettype wire

@@ sv/frc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frc_checker: port-level checks for the frame receiver
// Watches the stream ports of the deframer and flags protocol and
// result-format slips.
// ----------------------------------------------------------------------------
module frc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [frc_pkg::OUT_DATA_W-1:0]  m_tdata,
	input wire logic [frc_pkg::STATUS_W-1:0]    m_tuser,
	input wire logic                            m_tlast
);

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed while stalled");

	// error words are zeroed and last
	a_err_format: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != frc_pkg::ST_BYTE |-> m_tlast && m_tdata == '0)
		else $error("malformed error word");

	// an aborted byte never produces a word
	a_abort_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
		else $error("word produced by an aborted byte");

	// no input taken in the middle of a packet readout
	a_no_input_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == frc_pkg::ST_BYTE && !m_tlast |-> !s_tready)
		else $error("input accepted during packet readout");

endmodule : frc_checker

bind frame_receiver_checksum frc_checker u_frc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
